// ===== src/ima_adpcm_encoder_defines.svh =====
// assertion macros for the adpcm encoder
`ifndef IMA_ADPCM_ENCODER_DEFINES_SVH
`define IMA_ADPCM_ENCODER_DEFINES_SVH

`ifndef SYNTH
`define IMA_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("assertion failed");
`define IMA_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define IMA_ASSERT_IMP(lbl, a, b)
`define IMA_ASSERT_NXT(lbl, a, b)
`endif

`endif

// ===== src/ima_enc_pkg.sv =====
`timescale 1ns / 1ps
package ima_enc_pkg;

  localparam logic [6:0]         STEP_LAST = 7'd88;
  localparam logic signed [15:0] PRED_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] PRED_MIN  = -16'sh8000;

  typedef struct packed {
    logic       fire;
    logic       eob;
    logic [3:0] code;
  } ima_enc_code_t;

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    unique case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    unique case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

// ===== src/ima_enc_if.sv =====
`timescale 1ns / 1ps
interface ima_enc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        end_of_block;

  modport source (output valid, output sample, output end_of_block, input ready);
  modport sink   (input valid, input sample, input end_of_block, output ready);
endinterface

interface ima_enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;

  modport source (output valid, output packed_byte, input ready);
  modport sink   (input valid, input packed_byte, output ready);
endinterface

// ===== src/ima_enc_quant.sv =====
`timescale 1ns / 1ps
module ima_enc_quant
  import ima_enc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic signed [15:0] sample_i,
  output logic [3:0]        code_o,
  output logic [6:0]        pos_o
);

  logic signed [15:0] pred_q, pred_d;
  logic [6:0]         pos_q, pos_d;

  logic [14:0]        step;
  logic signed [16:0] diff;
  logic [16:0]        neg_diff;
  logic               neg;
  logic [15:0]        mag, r1, r2, delta;
  logic               b2, b1, b0;
  logic signed [17:0] pnext;
  logic signed [4:0]  adj;
  logic signed [7:0]  pos_sum;

  always_comb begin
    step     = step_size(pos_q);
    diff     = {sample_i[15], sample_i} - {pred_q[15], pred_q};
    neg_diff = 17'(-diff);
    neg      = diff[16];
    mag      = neg ? neg_diff[15:0] : diff[15:0];

    b2 = mag >= {1'b0, step};
    r1 = b2 ? mag - {1'b0, step} : mag;
    b1 = r1 >= {2'b0, step[14:1]};
    r2 = b1 ? r1 - {2'b0, step[14:1]} : r1;
    b0 = r2 >= {3'b0, step[14:2]};

    delta = {4'b0, step[14:3]}
          + (b2 ? {1'b0, step} : 16'd0)
          + (b1 ? {2'b0, step[14:1]} : 16'd0)
          + (b0 ? {3'b0, step[14:2]} : 16'd0);

    if (neg) begin
      pnext = {{2{pred_q[15]}}, pred_q} - $signed({2'b0, delta});
    end else begin
      pnext = {{2{pred_q[15]}}, pred_q} + $signed({2'b0, delta});
    end

    // saturate to 16 bits
    if (pnext[17:15] == 3'b000 || pnext[17:15] == 3'b111) begin
      pred_d = pnext[15:0];
    end else begin
      pred_d = pnext[17] ? PRED_MIN : PRED_MAX;
    end

    adj     = index_adjust({b2, b1, b0});
    pos_sum = $signed({1'b0, pos_q}) + {{3{adj[4]}}, adj};
    priority if (pos_sum[7]) begin
      pos_d = 7'd0;
    end else if (pos_sum[6:0] > STEP_LAST) begin
      pos_d = STEP_LAST;
    end else begin
      pos_d = pos_sum[6:0];
    end

    code_o = {neg, b2, b1, b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q <= '0;
      pos_q  <= '0;
    end else if (fire_i) begin
      pred_q <= pred_d;
      pos_q  <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// ===== src/ima_enc_pack.sv =====
`timescale 1ns / 1ps
module ima_enc_pack
  import ima_enc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ima_enc_code_t code_i,
  output logic          can_take_o,
  ima_enc_out_if.source out_o
);

  logic [3:0] held_q, held_d;
  logic       pend_q, pend_d;
  logic       oval_q, oval_d;
  logic [7:0] obyte_q, obyte_d;
  logic       emit;

  assign can_take_o = !oval_q || out_o.ready;

  always_comb begin
    held_d  = held_q;
    pend_d  = pend_q;
    obyte_d = obyte_q;
    emit    = 1'b0;
    if (code_i.fire) begin
      priority if (pend_q) begin
        emit    = 1'b1;
        obyte_d = {code_i.code, held_q};
        held_d  = 4'd0;
        pend_d  = 1'b0;
      end else if (code_i.eob) begin
        emit    = 1'b1;
        obyte_d = {4'd0, code_i.code};
      end else begin
        held_d  = code_i.code;
        pend_d  = 1'b1;
      end
    end
    oval_d = emit || (oval_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pend_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      held_q <= held_d;
      pend_q <= pend_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      obyte_q <= obyte_d;
    end
  end

  assign out_o.valid       = oval_q;
  assign out_o.packed_byte = obyte_q;

endmodule

// ===== src/ima_adpcm_encoder.sv =====
// ima adpcm encoder, two 4-bit codes packed per output byte (one at an odd block end)
// a sample passes the input register, then the output byte register, to its byte
// one sample per cycle unless stalled; predictor and step index update per sample
// a stalled output holds the sample in the input register
// reset: predictor, step index and held code cleared, no item in flight
`timescale 1ns / 1ps
`include "ima_adpcm_encoder_defines.svh"
module ima_adpcm_encoder
  import ima_enc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  ima_enc_in_if.sink    in_i,
  ima_enc_out_if.source out_o
);

  logic          in_valid_q;
  logic [15:0]   sample_q;
  logic          eob_q;
  logic          can_take;
  logic          advance;
  logic [3:0]    code;
  logic [6:0]    pos;
  ima_enc_code_t code_s;

  assign advance    = in_valid_q && can_take;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      sample_q <= in_i.sample;
      eob_q    <= in_i.end_of_block;
    end
  end

  ima_enc_quant u_quant (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .sample_i ($signed(sample_q)),
    .code_o   (code),
    .pos_o    (pos)
  );

  assign code_s.fire = advance;
  assign code_s.eob  = eob_q;
  assign code_s.code = code;

  ima_enc_pack u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .code_i     (code_s),
    .can_take_o (can_take),
    .out_o      (out_o)
  );

  `IMA_ASSERT_IMP(a_pos_range, 1'b1, pos <= STEP_LAST)
  `IMA_ASSERT_IMP(a_no_overrun, out_o.valid && !out_o.ready, !advance)
  `IMA_ASSERT_NXT(a_hold_input, in_valid_q && !advance, in_valid_q && $stable(sample_q))

endmodule
